@@ rtl/dqvr_pkg.sv @@
`default_nettype none

package dqvr_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_RAW_W = STATUS_W + DATA_W + DATA_W + CNT_W + 1;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT  = 3'd0,
        MODE_PUSH_BACK   = 3'd1,
        MODE_POP_FRONT   = 3'd2,
        MODE_POP_BACK    = 3'd3,
        MODE_REMOVE_FIRST = 3'd4,
        MODE_REMOVE_ALL  = 3'd5,
        MODE_EXISTS      = 3'd6,
        MODE_CLEAR       = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_RD_FRONT,
        S_RD_BACK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic apply;
        logic rd_front;
        logic rd_back;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } stat_t;

    // logical position -> physical RAM address, circular from head
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [CNT_W-1:0] idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/dqvr_ram.sv @@
`default_nettype none

module dqvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dqvr_ctrl.sv @@
`default_nettype none

module dqvr_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire dqvr_pkg::stat_t stat,
    output dqvr_pkg::cmd_t      cmd
);

    dqvr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dqvr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            dqvr_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = dqvr_pkg::S_SCAN;
                end
            end
            dqvr_pkg::S_SCAN: begin
                // last compare completes in the cycle scan_end is seen
                if (stat.scan_end) begin
                    state_next = dqvr_pkg::S_APPLY;
                end else begin
                    cmd.scan_rd = 1'b1;
                end
            end
            dqvr_pkg::S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = dqvr_pkg::S_RD_FRONT;
            end
            dqvr_pkg::S_RD_FRONT: begin
                cmd.rd_front = 1'b1;
                state_next   = dqvr_pkg::S_RD_BACK;
            end
            dqvr_pkg::S_RD_BACK: begin
                cmd.rd_back = 1'b1;
                state_next  = dqvr_pkg::S_DONE;
            end
            dqvr_pkg::S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = dqvr_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dqvr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dqvr_datapath.sv @@
`default_nettype none

module dqvr_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dqvr_pkg::cmd_t                cmd,
    output dqvr_pkg::stat_t                    stat,
    input  wire logic [dqvr_pkg::MODE_W-1:0]   in_mode,
    input  wire logic [dqvr_pkg::DATA_W-1:0]   in_value,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [dqvr_pkg::OUT_W-1:0]    m_tdata
);

    localparam int AW = dqvr_pkg::ADDR_W;
    localparam int CW = dqvr_pkg::CNT_W;
    localparam int DW = dqvr_pkg::DATA_W;

    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    dqvr_pkg::mode_t   mode_reg;
    logic [DW-1:0]     value_reg;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     wr_idx_reg, wr_idx_next;
    logic              found_reg, found_next;
    logic              removed_reg, removed_next;
    logic              pend_reg;
    dqvr_pkg::status_t status_reg, status_next;
    logic [DW-1:0]     front_reg;
    logic              out_valid_reg, out_valid_next;
    logic [dqvr_pkg::OUT_W-1:0] out_data_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_rd_en;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic          is_remove;
    logic          match;
    logic          drop;
    logic          empty;
    logic          full;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [DW-1:0] front_out;
    logic [DW-1:0] back_out;

    dqvr_ram #(
        .WIDTH(DW),
        .DEPTH(dqvr_pkg::CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rd_en (ram_rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_remove = (mode_reg == dqvr_pkg::MODE_REMOVE_FIRST) ||
                       (mode_reg == dqvr_pkg::MODE_REMOVE_ALL);
    assign match     = (ram_rdata == value_reg);
    assign drop      = pend_reg && match && is_remove &&
                       ((mode_reg == dqvr_pkg::MODE_REMOVE_ALL) || !removed_reg);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(dqvr_pkg::CAPACITY));
    assign head_dec  = (head_reg == '0) ? AW'(dqvr_pkg::CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc  = (head_reg == AW'(dqvr_pkg::CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    assign stat.scan_end = (rd_idx_reg == count_reg);
    assign stat.out_free = !out_valid_reg || m_tready;

    // RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = dqvr_pkg::phys_addr(head_reg, wr_idx_reg);
        ram_wdata = ram_rdata;
        ram_rd_en = 1'b0;
        ram_raddr = dqvr_pkg::phys_addr(head_reg, rd_idx_reg);
        // compaction: survivors move down to the write index
        if (pend_reg && is_remove && !drop) begin
            ram_we = 1'b1;
        end
        if (cmd.apply && !full) begin
            if (mode_reg == dqvr_pkg::MODE_PUSH_FRONT) begin
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                ram_wdata = value_reg;
            end else if (mode_reg == dqvr_pkg::MODE_PUSH_BACK) begin
                ram_we    = 1'b1;
                ram_waddr = dqvr_pkg::phys_addr(head_reg, count_reg);
                ram_wdata = value_reg;
            end
        end
        if (cmd.scan_rd) begin
            ram_rd_en = 1'b1;
        end else if (cmd.rd_front) begin
            ram_rd_en = 1'b1;
            ram_raddr = head_reg;
        end else if (cmd.rd_back) begin
            ram_rd_en = 1'b1;
            ram_raddr = dqvr_pkg::phys_addr(head_reg, count_reg - 1'b1);
        end
    end

    // item state and operation
    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        found_next   = found_reg;
        removed_next = removed_reg;
        status_next  = status_reg;

        if (cmd.start) begin
            rd_idx_next  = '0;
            wr_idx_next  = '0;
            found_next   = 1'b0;
            removed_next = 1'b0;
        end
        if (cmd.scan_rd) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        if (pend_reg) begin
            if (match) begin
                found_next = 1'b1;
            end
            if (drop) begin
                removed_next = 1'b1;
            end else begin
                wr_idx_next = wr_idx_reg + 1'b1;
            end
        end

        if (cmd.apply) begin
            status_next = dqvr_pkg::ST_OK;
            case (mode_reg) inside
                dqvr_pkg::MODE_PUSH_FRONT: begin
                    if (full) begin
                        status_next = dqvr_pkg::ST_FULL;
                    end else begin
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                dqvr_pkg::MODE_PUSH_BACK: begin
                    if (full) begin
                        status_next = dqvr_pkg::ST_FULL;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                dqvr_pkg::MODE_POP_FRONT: begin
                    if (empty) begin
                        status_next = dqvr_pkg::ST_EMPTY;
                    end else begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                dqvr_pkg::MODE_POP_BACK: begin
                    if (empty) begin
                        status_next = dqvr_pkg::ST_EMPTY;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
                dqvr_pkg::MODE_REMOVE_FIRST, dqvr_pkg::MODE_REMOVE_ALL: begin
                    if (empty) begin
                        status_next = dqvr_pkg::ST_EMPTY;
                    end else if (!found_reg) begin
                        status_next = dqvr_pkg::ST_MISSING;
                    end else begin
                        count_next = wr_idx_reg;
                    end
                end
                dqvr_pkg::MODE_EXISTS: begin
                    if (empty) begin
                        status_next = dqvr_pkg::ST_EMPTY;
                    end else if (!found_reg) begin
                        status_next = dqvr_pkg::ST_MISSING;
                    end
                end
                default: begin
                    count_next = '0;
                end
            endcase
        end
    end

    assign front_out = empty ? '0 : front_reg;
    assign back_out  = empty ? '0 : ram_rdata;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            head_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            pend_reg      <= cmd.scan_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg  <= dqvr_pkg::mode_t'(in_mode);
            value_reg <= in_value;
        end
        rd_idx_reg  <= rd_idx_next;
        wr_idx_reg  <= wr_idx_next;
        found_reg   <= found_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        // read data during the back read is the front entry
        if (cmd.rd_back) begin
            front_reg <= ram_rdata;
        end
        if (cmd.load_out) begin
            out_data_reg <= dqvr_pkg::OUT_W'({found_reg, count_reg, back_out, front_out,
                                              status_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/deque_with_value_removal.sv @@
`default_nettype none

// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tuser = mode, s_tdata = value
// m_       out  m_tvalid/m_tready   m_tdata = status, front, back, count, found
//
// The block takes no new item until the last one is done; the time per item grows
// with N = entries held before the item (at most CAPACITY). Every item walks the
// stored entries through the single read port of the entry RAM to find a
// match and, for removals, to close gaps; then front and back are read back.
// Reset (aresetn low, synchronous) empties the store; entries need no clearing.
// The next item is taken while a result waits; the block stalls in its last
// step only until the output register is free again.
module deque_with_value_removal (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] value
    input  wire logic [dqvr_pkg::DATA_W-1:0]     s_tdata,
    // [2:0] mode
    input  wire logic [dqvr_pkg::MODE_W-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] status, [33:2] front_value, [65:34] back_value,
    // [70:66] entry_count, [71] found
    output logic      [dqvr_pkg::OUT_W-1:0]      m_tdata
);

    dqvr_pkg::cmd_t  cmd;
    dqvr_pkg::stat_t stat;

    dqvr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dqvr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_mode  (s_tuser),
        .in_value (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ test/deque_with_value_removal_checker.sv @@
`default_nettype none

module deque_with_value_removal_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [dqvr_pkg::DATA_W-1:0]   s_tdata,
    input  wire logic [dqvr_pkg::MODE_W-1:0]   s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [dqvr_pkg::OUT_W-1:0]    m_tdata,
    output int                                 mismatches,
    output int                                 items_taken,
    output int                                 results_seen,
    output int                                 full_drops,
    output int                                 empty_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = dqvr_pkg::DATA_W;
    localparam int CW = dqvr_pkg::CNT_W;
    localparam int SW = dqvr_pkg::STATUS_W;

    typedef struct packed {
        dqvr_pkg::status_t status;
        logic [DW-1:0]     front;
        logic [DW-1:0]     back;
        logic [CW-1:0]     count;
        logic              found;
    } deque_view_t;

    logic [DW-1:0] model_entries[$];
    deque_view_t   pending_views[$];

    task automatic advance_deque(input dqvr_pkg::mode_t op, input logic [DW-1:0] v,
                                 output deque_view_t view);
        logic          hit;
        int            i;
        int            first_pos;
        logic [DW-1:0] kept[$];
        hit = 1'b0;
        first_pos = -1;
        for (i = 0; i < model_entries.size(); i++) begin
            if (model_entries[i] == v && !hit) begin
                hit = 1'b1;
                first_pos = i;
            end
        end
        view.status = dqvr_pkg::ST_OK;
        case (op)
            dqvr_pkg::MODE_PUSH_FRONT: begin
                if (model_entries.size() >= dqvr_pkg::CAPACITY) view.status = dqvr_pkg::ST_FULL;
                else model_entries.push_front(v);
            end
            dqvr_pkg::MODE_PUSH_BACK: begin
                if (model_entries.size() >= dqvr_pkg::CAPACITY) view.status = dqvr_pkg::ST_FULL;
                else model_entries.push_back(v);
            end
            dqvr_pkg::MODE_POP_FRONT: begin
                if (model_entries.size() == 0) view.status = dqvr_pkg::ST_EMPTY;
                else void'(model_entries.pop_front());
            end
            dqvr_pkg::MODE_POP_BACK: begin
                if (model_entries.size() == 0) view.status = dqvr_pkg::ST_EMPTY;
                else void'(model_entries.pop_back());
            end
            dqvr_pkg::MODE_REMOVE_FIRST: begin
                if (model_entries.size() == 0) view.status = dqvr_pkg::ST_EMPTY;
                else if (!hit) view.status = dqvr_pkg::ST_MISSING;
                else model_entries.delete(first_pos);
            end
            dqvr_pkg::MODE_REMOVE_ALL: begin
                if (model_entries.size() == 0) view.status = dqvr_pkg::ST_EMPTY;
                else if (!hit) view.status = dqvr_pkg::ST_MISSING;
                else begin
                    for (i = 0; i < model_entries.size(); i++)
                        if (model_entries[i] != v) kept.push_back(model_entries[i]);
                    model_entries = kept;
                end
            end
            dqvr_pkg::MODE_EXISTS: begin
                if (model_entries.size() == 0) view.status = dqvr_pkg::ST_EMPTY;
                else if (!hit) view.status = dqvr_pkg::ST_MISSING;
            end
            default: begin
                model_entries.delete();
            end
        endcase
        view.count = CW'(model_entries.size());
        view.front = (model_entries.size() != 0) ? model_entries[0] : '0;
        view.back  = (model_entries.size() != 0) ? model_entries[$] : '0;
        view.found = hit;
    endtask

    always @(posedge aclk) begin
        deque_view_t want;
        deque_view_t got;
        if (!aresetn) begin
            model_entries.delete();
            pending_views.delete();
            mismatches   <= 0;
            items_taken  <= 0;
            results_seen <= 0;
            full_drops   <= 0;
            empty_hits   <= 0;
        end else begin
            // result side first: an item taken at this edge cannot be answered here
            if (m_tvalid && m_tready) begin
                got.status = dqvr_pkg::status_t'(m_tdata[SW-1:0]);
                got.front  = m_tdata[SW +: DW];
                got.back   = m_tdata[SW+DW +: DW];
                got.count  = m_tdata[SW+2*DW +: CW];
                got.found  = m_tdata[SW+2*DW+CW];
                results_seen <= results_seen + 1;
                if (pending_views.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result st=%0d f=%h b=%h n=%0d fd=%b",
                                 $realtime, got.status, got.front, got.back, got.count,
                                 got.found);
                    mismatches <= mismatches + 1;
                end else begin
                    want = pending_views.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  exp st=%0d f=%h b=%h n=%0d fd=%b", want.status,
                                     want.front, want.back, want.count, want.found);
                            $display("  got st=%0d f=%h b=%h n=%0d fd=%b", got.status,
                                     got.front, got.back, got.count, got.found);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_deque(dqvr_pkg::mode_t'(s_tuser), s_tdata, want);
                pending_views.push_back(want);
                items_taken <= items_taken + 1;
                if (want.status == dqvr_pkg::ST_FULL)  full_drops <= full_drops + 1;
                if (want.status == dqvr_pkg::ST_EMPTY) empty_hits <= empty_hits + 1;
            end
        end
    end

endmodule

`default_nettype wire

@@ test/deque_with_value_removal_test.sv @@
`default_nettype none

module deque_with_value_removal_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW           = dqvr_pkg::DATA_W;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_TAIL   = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [DW-1:0]                 s_tdata;
    logic [dqvr_pkg::MODE_W-1:0]   s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [dqvr_pkg::OUT_W-1:0]    m_tdata;

    int mismatches, items_taken, results_seen, full_drops, empty_hits;

    logic          quiet;
    int            tx_gap_pct;
    logic [DW-1:0] value_pool[8];
    int            directed_items;

    deque_with_value_removal DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    deque_with_value_removal_checker watch (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatches(mismatches), .items_taken(items_taken), .results_seen(results_seen),
        .full_drops(full_drops), .empty_hits(empty_hits)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic offer_item(input dqvr_pkg::mode_t op, input logic [DW-1:0] v);
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly pool values so removals and lookups hit
    function automatic logic [DW-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return value_pool[$urandom_range(0, 7)];
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // growing phases lean on pushes, shrinking phases on pops and removals
    function automatic dqvr_pkg::mode_t pick_mode(input logic growing);
        int r;
        r = $urandom_range(0, 99);
        if (growing) begin
            if (r < 28) return dqvr_pkg::MODE_PUSH_FRONT;
            if (r < 56) return dqvr_pkg::MODE_PUSH_BACK;
            if (r < 63) return dqvr_pkg::MODE_POP_FRONT;
            if (r < 70) return dqvr_pkg::MODE_POP_BACK;
            if (r < 80) return dqvr_pkg::MODE_REMOVE_FIRST;
            if (r < 88) return dqvr_pkg::MODE_REMOVE_ALL;
            if (r < 98) return dqvr_pkg::MODE_EXISTS;
            return dqvr_pkg::MODE_CLEAR;
        end
        if (r < 10) return dqvr_pkg::MODE_PUSH_FRONT;
        if (r < 20) return dqvr_pkg::MODE_PUSH_BACK;
        if (r < 38) return dqvr_pkg::MODE_POP_FRONT;
        if (r < 56) return dqvr_pkg::MODE_POP_BACK;
        if (r < 70) return dqvr_pkg::MODE_REMOVE_FIRST;
        if (r < 80) return dqvr_pkg::MODE_REMOVE_ALL;
        if (r < 95) return dqvr_pkg::MODE_EXISTS;
        return dqvr_pkg::MODE_CLEAR;
    endfunction

    // result side: random stalls plus one long hold-off to back up the input
    initial begin
        int got;
        int rx_stall_pct;
        logic held_off;
        got = 0;
        rx_stall_pct = 10;
        held_off = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_off && got >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got++;
                if (got % 100 == 0) rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            end
        end
    end

    initial begin
        logic [DW-1:0] fill;
        logic          growing;
        int            n;
        int            i;
        int            drain;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        quiet      = 1'b0;
        tx_gap_pct = 20;
        for (i = 0; i < 8; i++) value_pool[i] = $urandom;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store: every operation but the pushes
        offer_item(dqvr_pkg::MODE_POP_FRONT, 32'h1234_5678);
        offer_item(dqvr_pkg::MODE_POP_BACK, 32'h0);
        offer_item(dqvr_pkg::MODE_REMOVE_FIRST, 32'h0);
        offer_item(dqvr_pkg::MODE_REMOVE_ALL, 32'hFFFF_FFFF);
        offer_item(dqvr_pkg::MODE_EXISTS, 32'h0);
        offer_item(dqvr_pkg::MODE_CLEAR, 32'h0);
        // extremes at both ends, then matches at front and back
        offer_item(dqvr_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF);
        offer_item(dqvr_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        offer_item(dqvr_pkg::MODE_PUSH_BACK, 32'h0000_0000);
        offer_item(dqvr_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        offer_item(dqvr_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF);
        offer_item(dqvr_pkg::MODE_EXISTS, 32'h0000_0000);
        offer_item(dqvr_pkg::MODE_EXISTS, 32'h0000_0005);
        offer_item(dqvr_pkg::MODE_REMOVE_FIRST, 32'h0000_0005);
        offer_item(dqvr_pkg::MODE_REMOVE_ALL, 32'hFFFF_FFFF);
        offer_item(dqvr_pkg::MODE_REMOVE_FIRST, 32'h7FFF_FFFF);
        offer_item(dqvr_pkg::MODE_POP_FRONT, 32'h0);
        offer_item(dqvr_pkg::MODE_POP_BACK, 32'h0);
        offer_item(dqvr_pkg::MODE_CLEAR, 32'h0);
        // fill to capacity, push into a full store, then one removal empties it
        fill = $urandom;
        repeat (dqvr_pkg::CAPACITY) offer_item(dqvr_pkg::MODE_PUSH_BACK, fill);
        offer_item(dqvr_pkg::MODE_PUSH_FRONT, 32'h0BAD_0BAD);
        offer_item(dqvr_pkg::MODE_PUSH_BACK, 32'hF00D_F00D);
        offer_item(dqvr_pkg::MODE_REMOVE_ALL, fill);
        directed_items = 22 + dqvr_pkg::CAPACITY;

        growing = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) growing = ($urandom_range(0, 1) == 1);
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 20;
                    default: tx_gap_pct = 50;
                endcase
            end
            if (n >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
            offer_item(pick_mode(growing), pick_value());
        end
        s_tvalid <= 1'b0;

        while (results_seen < items_taken) @(posedge aclk);
        for (drain = 0; drain < 4 * (dqvr_pkg::CAPACITY + 5); drain++) @(posedge aclk);

        $display("Covered %0d items (%0d directed, rest random over 8 values and extremes)",
                 items_taken, directed_items);
        $display("Checked %0d results; %0d pushes hit a full store, %0d ops an empty one",
                 results_seen, full_drops, empty_hits);
        if (mismatches == 0 && results_seen == items_taken) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout after %0d of %0d results", results_seen, items_taken);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/dqvr_pkg.sv
rtl/dqvr_ram.sv
rtl/dqvr_ctrl.sv
rtl/dqvr_datapath.sv
rtl/deque_with_value_removal.sv
test/deque_with_value_removal_checker.sv
test/deque_with_value_removal_test.sv
